// ===== src/psgfx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psgfx_pkg
// types, codes and control bundles shared by the effect channel engine
// ----------------------------------------------------------------------------
package psgfx_pkg;

   localparam logic [1:0] MODE_TICK = 2'd0;
   localparam logic [1:0] MODE_PLAY = 2'd1;
   localparam logic [1:0] MODE_LOAD = 2'd2;

   localparam logic [1:0] STAGE_ATTACK  = 2'd0;
   localparam logic [1:0] STAGE_SUSTAIN = 2'd1;
   localparam logic [1:0] STAGE_DECAY   = 2'd2;

   localparam logic [3:0] SEL_VOLUME     = 4'd0;
   localparam logic [3:0] SEL_ATK_STEP   = 4'd1;
   localparam logic [3:0] SEL_ATK_LEN    = 4'd2;
   localparam logic [3:0] SEL_SUS_LEN    = 4'd3;
   localparam logic [3:0] SEL_DEC_STEP   = 4'd4;
   localparam logic [3:0] SEL_DEC_LEN    = 4'd5;
   localparam logic [3:0] SEL_SWEEP_MASK = 4'd6;
   localparam logic [3:0] SEL_FREQ       = 4'd7;
   localparam logic [3:0] SEL_FREQ_STEP  = 4'd8;
   localparam logic [3:0] SEL_DIRECTION  = 4'd9;
   localparam logic [3:0] SEL_WAVEFORM   = 4'd10;
   localparam logic [3:0] SEL_PULSE      = 4'd11;

   localparam logic [7:0] GAIN_STOP_LIMIT = 8'h3F;

   typedef struct packed {
      logic [1:0]  mode;
      logic [5:0]  effect_index;
      logic [7:0]  priority_req;
      logic [5:0]  pan_left_in;
      logic [5:0]  pan_right_in;
      logic [3:0]  param_select;
      logic [15:0] param_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  channel;
      logic        stopped;
      logic [15:0] tone_frequency;
      logic [5:0]  out_volume_left;
      logic [5:0]  out_volume_right;
      logic [1:0]  waveform;
      logic [5:0]  out_pulse_width;
      logic        last;
   } rsp_type;

   // one effect table entry
   typedef struct packed {
      logic [5:0]  pulse;
      logic [1:0]  waveform;
      logic        direction;
      logic [15:0] freq_step;
      logic [15:0] freq;
      logic [7:0]  sweep_mask;
      logic [7:0]  dec_len;
      logic [7:0]  dec_step;
      logic [7:0]  sus_len;
      logic [7:0]  atk_len;
      logic [7:0]  atk_step;
      logic [7:0]  volume;
   } effect_type;

   typedef struct packed {
      logic capture;
      logic mem_rd;
      logic mem_rd_chan;
      logic load_wr;
      logic ch_clear;
      logic ch_inc;
      logic scan;
      logic ch_take_use;
      logic play_set;
      logic tick_upd;
      logic emit;
      logic frame_inc;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       idx_ok;
      logic       ch_active;
      logic       ch_is_last;
      logic       scan_hit;
      logic       out_free;
   } status_type;

endpackage

// ===== src/psg_effect_channel_engine_core.sv =====
`timescale 1ns / 1ps
// a load passes decode, table read and table write; a play passes decode, scans channels
// one per cycle, then reads the table, sets the channel and emits; a tick walks inactive
// channels one per cycle, and each active one also reads, updates and emits; emit waits
// for rsp_ready. one item at a time: a new request is taken only once the last is done
// reset: synchronous, clears channels and frame counter; effect table is not cleared
// ----------------------------------------------------------------------------
// psg_effect_channel_engine_core
// multi-channel sound effect engine with attack / sustain / decay envelopes
// ----------------------------------------------------------------------------
module psg_effect_channel_engine_core
   import psgfx_pkg::*;
#(
   parameter int CHANNELS = 4,
   parameter int EFFECTS  = 64
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // command and status bundle between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: decodes the transfer and steps channels one at a time
   psgfx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: effect table, channel state and output register
   psgfx_datapath #(
      .CHANNELS (CHANNELS),
      .EFFECTS  (EFFECTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/psgfx_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psgfx_ctrl
// sequencer for load, play and tick items
// ----------------------------------------------------------------------------
module psgfx_ctrl
   import psgfx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_LOAD_RD  = 4'd2;
   localparam logic [3:0] S_LOAD_WR  = 4'd3;
   localparam logic [3:0] S_SCAN     = 4'd4;
   localparam logic [3:0] S_PLAY_RD  = 4'd5;
   localparam logic [3:0] S_PLAY_SET = 4'd6;
   localparam logic [3:0] S_TICK_CHK = 4'd7;
   localparam logic [3:0] S_TICK_UPD = 4'd8;
   localparam logic [3:0] S_EMIT     = 4'd9;

   logic [3:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.mode)
               MODE_TICK: begin
                  cmd.ch_clear = 1'b1;
                  state_in     = S_TICK_CHK;
               end
               MODE_PLAY: begin
                  cmd.ch_clear = 1'b1;
                  state_in     = status.idx_ok ? S_SCAN : S_IDLE;
               end
               MODE_LOAD: state_in = status.idx_ok ? S_LOAD_RD : S_IDLE;
               default:   state_in = S_IDLE;
            endcase
         end
         S_LOAD_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_LOAD_WR;
         end
         S_LOAD_WR: begin
            cmd.load_wr = 1'b1;
            state_in    = S_IDLE;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (!status.ch_active) begin
               state_in = S_PLAY_RD;
            end else if (status.ch_is_last) begin
               state_in = status.scan_hit ? S_PLAY_RD : S_IDLE;
            end else begin
               cmd.ch_inc = 1'b1;
            end
         end
         S_PLAY_RD: begin
            cmd.mem_rd      = 1'b1;
            cmd.ch_take_use = 1'b1;
            state_in        = S_PLAY_SET;
         end
         S_PLAY_SET: begin
            cmd.play_set = 1'b1;
            state_in     = S_EMIT;
         end
         S_TICK_CHK: begin
            if (status.ch_active) begin
               cmd.mem_rd      = 1'b1;
               cmd.mem_rd_chan = 1'b1;
               state_in        = S_TICK_UPD;
            end else if (status.ch_is_last) begin
               cmd.frame_inc = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.ch_inc = 1'b1;
            end
         end
         S_TICK_UPD: begin
            cmd.tick_upd = 1'b1;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.mode == MODE_TICK) begin
                  if (status.ch_is_last) begin
                     cmd.frame_inc = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     cmd.ch_inc = 1'b1;
                     state_in   = S_TICK_CHK;
                  end
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/psgfx_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psgfx_datapath
// effect table, channel registers, envelope step and result register
// ----------------------------------------------------------------------------
module psgfx_datapath
   import psgfx_pkg::*;
#(
   parameter int CHANNELS = 4,
   parameter int EFFECTS  = 64
)(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DEPTH = (EFFECTS < 64) ? EFFECTS : 64;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [CW-1:0] LAST_CH = CW'(CHANNELS - 1);

   effect_type table_mem [DEPTH];
   effect_type mem_q_ff;

   req_type        req_ff;
   logic [CW-1:0]  chan_ff, use_ff;
   logic           found_ff;
   logic [7:0]     frame_ff;
   logic           stop_ff, last_ff;

   logic           active_ff [CHANNELS];
   logic [5:0]     effect_ff [CHANNELS];
   logic [7:0]     prio_ff   [CHANNELS];
   logic [1:0]     stage_ff  [CHANNELS];
   logic [7:0]     frames_ff [CHANNELS];
   logic [7:0]     gain_ff   [CHANNELS];
   logic [15:0]    freq_ff   [CHANNELS];
   logic [5:0]     pulse_ff  [CHANNELS];
   logic [5:0]     panl_ff   [CHANNELS];
   logic [5:0]     panr_ff   [CHANNELS];

   rsp_type        rsp_ff;
   logic           rsp_valid_ff;

   logic [5:0]     rd_addr;
   effect_type     merged;
   logic           more_after;
   logic [7:0]     g_add, g_sub, n_gain, n_frames;
   logic [1:0]     n_stage;
   logic           n_stop;
   logic [5:0]     n_pulse;
   logic [15:0]    n_freq;
   logic [13:0]    prod_l, prod_r;
   logic           out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   assign status.mode       = req_ff.mode;
   assign status.idx_ok     = (int'(req_ff.effect_index) < EFFECTS);
   assign status.ch_active  = active_ff[chan_ff];
   assign status.ch_is_last = (chan_ff == LAST_CH);
   assign status.scan_hit   = found_ff || (req_ff.priority_req > prio_ff[chan_ff]);
   assign status.out_free   = out_free;

   assign rd_addr = cmd.mem_rd_chan ? effect_ff[chan_ff] : req_ff.effect_index;

   // table read-modify-write for loads
   always_comb begin
      merged = mem_q_ff;
      case (req_ff.param_select)
         SEL_VOLUME:     merged.volume     = req_ff.param_value[7:0];
         SEL_ATK_STEP:   merged.atk_step   = req_ff.param_value[7:0];
         SEL_ATK_LEN:    merged.atk_len    = req_ff.param_value[7:0];
         SEL_SUS_LEN:    merged.sus_len    = req_ff.param_value[7:0];
         SEL_DEC_STEP:   merged.dec_step   = req_ff.param_value[7:0];
         SEL_DEC_LEN:    merged.dec_len    = req_ff.param_value[7:0];
         SEL_SWEEP_MASK: merged.sweep_mask = req_ff.param_value[7:0];
         SEL_FREQ:       merged.freq       = req_ff.param_value;
         SEL_FREQ_STEP:  merged.freq_step  = req_ff.param_value;
         SEL_DIRECTION:  merged.direction  = req_ff.param_value[0];
         SEL_WAVEFORM:   merged.waveform   = req_ff.param_value[1:0];
         SEL_PULSE:      merged.pulse      = req_ff.param_value[5:0];
         default:        merged = mem_q_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         mem_q_ff <= table_mem[rd_addr[AW-1:0]];
      end
      if (cmd.load_wr) begin
         table_mem[req_ff.effect_index[AW-1:0]] <= merged;
      end
   end

   // envelope and sweep step for the current channel
   always_comb begin
      more_after = 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (CW'(i) > chan_ff && active_ff[i]) more_after = 1'b1;
      end
      g_add    = gain_ff[chan_ff] + mem_q_ff.atk_step;
      g_sub    = gain_ff[chan_ff] - mem_q_ff.dec_step;
      n_gain   = gain_ff[chan_ff];
      n_stage  = stage_ff[chan_ff];
      n_frames = frames_ff[chan_ff];
      n_stop   = 1'b0;
      if (frames_ff[chan_ff] == 8'd0) begin
         case (stage_ff[chan_ff])
            STAGE_ATTACK: begin
               if (g_add >= mem_q_ff.volume) begin
                  n_gain   = mem_q_ff.volume;
                  n_stage  = STAGE_SUSTAIN;
                  n_frames = mem_q_ff.sus_len;
               end else begin
                  n_gain   = g_add;
                  n_frames = mem_q_ff.atk_len;
               end
            end
            STAGE_SUSTAIN: n_stage = STAGE_DECAY;
            STAGE_DECAY: begin
               n_gain   = g_sub;
               n_frames = mem_q_ff.dec_len;
               if (g_sub == 8'd0 || g_sub > GAIN_STOP_LIMIT) n_stop = 1'b1;
            end
            default: n_stage = stage_ff[chan_ff];
         endcase
      end else begin
         n_frames = frames_ff[chan_ff] - 8'd1;
      end
      n_pulse = pulse_ff[chan_ff];
      if ((frame_ff & mem_q_ff.sweep_mask) != 8'd0) begin
         n_pulse = mem_q_ff.direction ? pulse_ff[chan_ff] + 6'd1 : pulse_ff[chan_ff] - 6'd1;
      end
      n_freq = mem_q_ff.direction ? freq_ff[chan_ff] + mem_q_ff.freq_step
                                  : freq_ff[chan_ff] - mem_q_ff.freq_step;
   end

   assign prod_l = gain_ff[chan_ff] * panl_ff[chan_ff];
   assign prod_r = gain_ff[chan_ff] * panr_ff[chan_ff];

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.ch_take_use) chan_ff <= use_ff;
      else if (cmd.ch_clear) chan_ff <= '0;
      else if (cmd.ch_inc) chan_ff <= chan_ff + CW'(1);
      if (cmd.scan) begin
         if (!active_ff[chan_ff] || req_ff.priority_req > prio_ff[chan_ff]) begin
            use_ff <= chan_ff;
         end
      end
      if (cmd.play_set) begin
         stop_ff <= 1'b0;
         last_ff <= 1'b1;
      end
      if (cmd.tick_upd) begin
         stop_ff <= n_stop;
         last_ff <= !more_after;
      end
      if (cmd.emit) begin
         rsp_ff.channel          <= 2'(chan_ff);
         rsp_ff.stopped          <= stop_ff;
         rsp_ff.last             <= last_ff;
         rsp_ff.tone_frequency   <= stop_ff ? 16'd0 : freq_ff[chan_ff];
         rsp_ff.out_volume_left  <= stop_ff ? 6'd0 : prod_l[11:6];
         rsp_ff.out_volume_right <= stop_ff ? 6'd0 : prod_r[11:6];
         rsp_ff.waveform         <= stop_ff ? 2'd0 : mem_q_ff.waveform;
         rsp_ff.out_pulse_width  <= stop_ff ? 6'd0 : pulse_ff[chan_ff];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff     <= 1'b0;
         frame_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            active_ff[i] <= 1'b0;
            effect_ff[i] <= 6'd0;
            prio_ff[i]   <= 8'd0;
            stage_ff[i]  <= STAGE_ATTACK;
            frames_ff[i] <= 8'd0;
            gain_ff[i]   <= 8'd0;
            freq_ff[i]   <= 16'd0;
            pulse_ff[i]  <= 6'd0;
            panl_ff[i]   <= 6'd0;
            panr_ff[i]   <= 6'd0;
         end
      end else begin
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (cmd.frame_inc) frame_ff <= frame_ff + 8'd1;
         if (cmd.capture) found_ff <= 1'b0;
         else if (cmd.scan && req_ff.priority_req > prio_ff[chan_ff]) found_ff <= 1'b1;
         if (cmd.play_set) begin
            active_ff[chan_ff] <= 1'b1;
            effect_ff[chan_ff] <= req_ff.effect_index;
            prio_ff[chan_ff]   <= req_ff.priority_req;
            stage_ff[chan_ff]  <= STAGE_ATTACK;
            frames_ff[chan_ff] <= mem_q_ff.atk_len;
            gain_ff[chan_ff]   <= 8'd0;
            panl_ff[chan_ff]   <= req_ff.pan_left_in;
            panr_ff[chan_ff]   <= req_ff.pan_right_in;
            freq_ff[chan_ff]   <= mem_q_ff.freq;
            pulse_ff[chan_ff]  <= mem_q_ff.pulse;
         end
         if (cmd.tick_upd) begin
            if (n_stop) begin
               active_ff[chan_ff] <= 1'b0;
            end else begin
               stage_ff[chan_ff]  <= n_stage;
               frames_ff[chan_ff] <= n_frames;
               gain_ff[chan_ff]   <= n_gain;
               pulse_ff[chan_ff]  <= n_pulse;
               freq_ff[chan_ff]   <= n_freq;
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives loads, plays and frame ticks into the effect channel engine, keeps
// its own channel and effect table state, and checks every channel update
// ----------------------------------------------------------------------------
module testbench;
   import psgfx_pkg::*;

   localparam int NCH = 4;
   localparam int NFX = 64;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   psg_effect_channel_engine_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // predicted engine state
   effect_type fx_table [NFX];
   bit         fx_written [NFX];
   logic       ch_on [NCH];
   logic [5:0] ch_fx [NCH];
   logic [7:0] ch_prio [NCH];
   logic [1:0] ch_stage [NCH];
   logic [7:0] ch_frames [NCH];
   logic [7:0] ch_gain [NCH];
   logic [15:0] ch_freq [NCH];
   logic [5:0] ch_pulse [NCH];
   logic [5:0] ch_pl [NCH];
   logic [5:0] ch_pr [NCH];
   logic [7:0] frame_cnt;

   req_type pending_reqs [$];
   rsp_type expected_updates [$];
   int      errors = 0;
   bit      calm = 0;
   int      req_gap = 0;
   int      rsp_gap = 0;
   bit      req_taken = 0;

   function automatic rsp_type channel_update(int c);
      rsp_type r;
      logic [13:0] pl, pr;
      r = '0;
      pl = ch_gain[c] * ch_pl[c];
      pr = ch_gain[c] * ch_pr[c];
      r.channel = c[1:0];
      r.tone_frequency = ch_freq[c];
      r.out_volume_left = pl[11:6];
      r.out_volume_right = pr[11:6];
      r.waveform = fx_table[ch_fx[c]].waveform;
      r.out_pulse_width = ch_pulse[c];
      return r;
   endfunction

   // work out the updates one accepted transfer causes
   task automatic predict_engine(req_type q);
      rsp_type    outs [$];
      rsp_type    r;
      effect_type fx;
      int         use_ch;
      logic [7:0] g;
      logic [1:0] st;
      logic [7:0] fr;
      case (q.mode)
         MODE_LOAD: begin
            fx = fx_table[q.effect_index];
            case (q.param_select)
               SEL_VOLUME:     fx.volume = q.param_value[7:0];
               SEL_ATK_STEP:   fx.atk_step = q.param_value[7:0];
               SEL_ATK_LEN:    fx.atk_len = q.param_value[7:0];
               SEL_SUS_LEN:    fx.sus_len = q.param_value[7:0];
               SEL_DEC_STEP:   fx.dec_step = q.param_value[7:0];
               SEL_DEC_LEN:    fx.dec_len = q.param_value[7:0];
               SEL_SWEEP_MASK: fx.sweep_mask = q.param_value[7:0];
               SEL_FREQ:       fx.freq = q.param_value;
               SEL_FREQ_STEP:  fx.freq_step = q.param_value;
               SEL_DIRECTION:  fx.direction = q.param_value[0];
               SEL_WAVEFORM:   fx.waveform = q.param_value[1:0];
               SEL_PULSE:      fx.pulse = q.param_value[5:0];
               default: ;
            endcase
            fx_table[q.effect_index] = fx;
         end
         MODE_PLAY: begin
            use_ch = -1;
            for (int c = 0; c < NCH; c++) begin
               if (!ch_on[c]) begin
                  use_ch = c;
                  break;
               end
               if (q.priority_req > ch_prio[c]) use_ch = c;
            end
            if (use_ch >= 0) begin
               fx = fx_table[q.effect_index];
               ch_on[use_ch] = 1'b1;
               ch_fx[use_ch] = q.effect_index;
               ch_prio[use_ch] = q.priority_req;
               ch_stage[use_ch] = STAGE_ATTACK;
               ch_frames[use_ch] = fx.atk_len;
               ch_gain[use_ch] = 8'd0;
               ch_pl[use_ch] = q.pan_left_in;
               ch_pr[use_ch] = q.pan_right_in;
               ch_freq[use_ch] = fx.freq;
               ch_pulse[use_ch] = fx.pulse;
               outs.push_back(channel_update(use_ch));
            end
         end
         MODE_TICK: begin
            for (int c = 0; c < NCH; c++) begin
               if (!ch_on[c]) continue;
               fx = fx_table[ch_fx[c]];
               g = ch_gain[c];
               st = ch_stage[c];
               fr = ch_frames[c];
               if (fr == 8'd0) begin
                  if (st == STAGE_ATTACK) begin
                     g = g + fx.atk_step;
                     if (g >= fx.volume) begin
                        g = fx.volume;
                        st = STAGE_SUSTAIN;
                        fr = fx.sus_len;
                     end else begin
                        fr = fx.atk_len;
                     end
                  end else if (st == STAGE_SUSTAIN) begin
                     st = STAGE_DECAY;
                  end else if (st == STAGE_DECAY) begin
                     g = g - fx.dec_step;
                     if (g == 8'd0 || g > GAIN_STOP_LIMIT) begin
                        ch_on[c] = 1'b0;
                        r = '0;
                        r.channel = c[1:0];
                        r.stopped = 1'b1;
                        outs.push_back(r);
                        continue;
                     end
                     fr = fx.dec_len;
                  end
               end else begin
                  fr = fr - 8'd1;
               end
               if ((frame_cnt & fx.sweep_mask) != 8'd0)
                  ch_pulse[c] = fx.direction ? ch_pulse[c] + 6'd1 : ch_pulse[c] - 6'd1;
               ch_freq[c] = fx.direction ? ch_freq[c] + fx.freq_step
                                         : ch_freq[c] - fx.freq_step;
               ch_stage[c] = st;
               ch_frames[c] = fr;
               ch_gain[c] = g;
               outs.push_back(channel_update(c));
            end
            frame_cnt = frame_cnt + 8'd1;
         end
         default: ;
      endcase
      if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
      foreach (outs[i]) expected_updates.push_back(outs[i]);
   endtask

   // driver: inputs change on the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
            // hold the transfer
         end else if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            req_gap <= $urandom_range(0, 2);
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_data <= pending_reqs.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_gap <= $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor: sample at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) predict_engine(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_updates.size() == 0) begin
               $error("unexpected update transfer %p", rsp_data);
               errors++;
            end else begin
               rsp_type x;
               x = expected_updates.pop_front();
               if (rsp_data.channel !== x.channel) begin
                  $error("channel exp %0d got %0d", x.channel, rsp_data.channel);
                  errors++;
               end
               if (rsp_data.stopped !== x.stopped) begin
                  $error("stopped exp %0d got %0d", x.stopped, rsp_data.stopped);
                  errors++;
               end
               if (rsp_data.tone_frequency !== x.tone_frequency) begin
                  $error("tone_frequency exp %0h got %0h", x.tone_frequency,
                         rsp_data.tone_frequency);
                  errors++;
               end
               if (rsp_data.out_volume_left !== x.out_volume_left) begin
                  $error("out_volume_left exp %0d got %0d", x.out_volume_left,
                         rsp_data.out_volume_left);
                  errors++;
               end
               if (rsp_data.out_volume_right !== x.out_volume_right) begin
                  $error("out_volume_right exp %0d got %0d", x.out_volume_right,
                         rsp_data.out_volume_right);
                  errors++;
               end
               if (rsp_data.waveform !== x.waveform) begin
                  $error("waveform exp %0d got %0d", x.waveform, rsp_data.waveform);
                  errors++;
               end
               if (rsp_data.out_pulse_width !== x.out_pulse_width) begin
                  $error("out_pulse_width exp %0d got %0d", x.out_pulse_width,
                         rsp_data.out_pulse_width);
                  errors++;
               end
               if (rsp_data.last !== x.last) begin
                  $error("last exp %0d got %0d", x.last, rsp_data.last);
                  errors++;
               end
            end
         end
      end
   end

   function automatic req_type load_item(logic [5:0] e, logic [3:0] sel, logic [15:0] v);
      req_type q;
      q = '0;
      q.mode = MODE_LOAD;
      q.effect_index = e;
      q.param_select = sel;
      q.param_value = v;
      return q;
   endfunction

   function automatic req_type play_item(logic [5:0] e, logic [7:0] p,
                                         logic [5:0] l, logic [5:0] r);
      req_type q;
      q = 48'({$urandom, $urandom});
      q.mode = MODE_PLAY;
      q.effect_index = e;
      q.priority_req = p;
      q.pan_left_in = l;
      q.pan_right_in = r;
      return q;
   endfunction

   function automatic req_type tick_item();
      req_type q;
      q = 48'({$urandom, $urandom});
      q.mode = MODE_TICK;
      return q;
   endfunction

   // short envelopes keep channels cycling through all stages
   task automatic queue_effect(logic [5:0] e, bit wild);
      for (int s = 0; s <= 11; s++) begin
         logic [15:0] v;
         v = 16'($urandom);
         if (!wild) begin
            case (s)
               0: v = 16'($urandom_range(1, 63));
               2, 3, 5: v = 16'($urandom_range(0, 3));
               4: v = 16'($urandom_range(1, 40));
               default: ;
            endcase
         end
         pending_reqs.push_back(load_item(e, s[3:0], v));
      end
      fx_written[e] = 1'b1;
   endtask

   function automatic logic [5:0] written_fx();
      logic [5:0] e;
      do e = 6'($urandom_range(0, NFX - 1)); while (!fx_written[e]);
      return e;
   endfunction

   initial begin
      req_type q;
      for (int c = 0; c < NCH; c++) begin
         ch_on[c] = 0; ch_fx[c] = 0; ch_prio[c] = 0; ch_stage[c] = STAGE_ATTACK;
         ch_frames[c] = 0; ch_gain[c] = 0; ch_freq[c] = 0; ch_pulse[c] = 0;
         ch_pl[c] = 0; ch_pr[c] = 0;
      end
      for (int e = 0; e < NFX; e++) begin
         fx_table[e] = '0;
         fx_written[e] = 0;
      end
      frame_cnt = 0;

      // directed: extreme effects, priority takeover, unused codes
      pending_reqs.push_back(tick_item());
      for (int s = 0; s <= 11; s++)
         pending_reqs.push_back(load_item(6'd0, s[3:0], 16'hFFFF));
      fx_written[0] = 1'b1;
      queue_effect(6'd63, 1'b0);
      pending_reqs.push_back(load_item(6'd63, 4'd15, 16'hFFFF));
      q = load_item(6'd63, 4'd12, 16'h0000);
      q.mode = 2'd3;
      pending_reqs.push_back(q);
      pending_reqs.push_back(play_item(6'd0, 8'hFF, 6'h3F, 6'h3F));
      pending_reqs.push_back(play_item(6'd63, 8'd0, 6'h00, 6'h3F));
      pending_reqs.push_back(play_item(6'd63, 8'd10, 6'h3F, 6'h00));
      pending_reqs.push_back(play_item(6'd63, 8'd20, 6'h15, 6'h2A));
      pending_reqs.push_back(play_item(6'd63, 8'd0, 6'h3F, 6'h3F));
      pending_reqs.push_back(play_item(6'd63, 8'd5, 6'h3F, 6'h3F));
      for (int i = 0; i < 4; i++) pending_reqs.push_back(tick_item());

      // random: a few effects, then mostly ticks and plays
      for (int i = 0; i < 3; i++) queue_effect(6'($urandom_range(0, NFX - 1)), i == 0);
      for (int i = 0; i < 75; i++) begin
         int k;
         k = $urandom_range(0, 99);
         if (k < 55) pending_reqs.push_back(tick_item());
         else if (k < 85)
            pending_reqs.push_back(play_item(written_fx(), 8'($urandom), 6'($urandom),
                                             6'($urandom)));
         else if (k < 95)
            pending_reqs.push_back(load_item(written_fx(), 4'($urandom_range(0, 15)),
                                             16'($urandom)));
         else begin
            q = 48'({$urandom, $urandom});
            q.mode = 2'd3;
            pending_reqs.push_back(q);
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      wait (pending_reqs.size() < 30);
      calm = 1;
      wait (pending_reqs.size() == 0 && !req_valid && expected_updates.size() == 0);
      repeat (40) @(posedge clock);
      if (errors == 0 && expected_updates.size() == 0) begin
         $display("psg_effect_channel_engine_core: match");
      end else begin
         $display("psg_effect_channel_engine_core: mismatch");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("psg_effect_channel_engine_core: mismatch");
      $finish;
   end

endmodule

// ===== sim.f =====
src/psgfx_pkg.sv
src/psgfx_ctrl.sv
src/psgfx_datapath.sv
src/psg_effect_channel_engine_core.sv
tb/sv/testbench.sv
